// ===== design/pa3_pkg.sv =====
`default_nettype none

package pa3_pkg;

  // field widths
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned SUM_W     = 44;
  localparam int unsigned AREA_W    = 51;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEGEN       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_NORMAL = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  // x in the lowest bits, as on the input beat
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vtx_t;

  // axis that is dropped by the projection
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // commands to the shoelace accumulator
  typedef enum logic [2:0] {
    SL_NOP,
    SL_VERTEX,
    SL_WRAP_A,
    SL_WRAP_B,
    SL_CLEAR
  } sl_cmd_e;

  // magnitude of a signed coordinate; the most negative value maps to 2^15
  function automatic logic [COORD_W-1:0] abs_coord(coord_t v);
    return v[COORD_W-1] ? COORD_W'(~v + 1'b1) : COORD_W'(v);
  endfunction

  // largest normal component; ties go to z, or to y when only x and y tie
  function automatic axis_e drop_axis(coord_t nx, coord_t ny, coord_t nz);
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] az;
    axis_e              res;
    ax  = abs_coord(nx);
    ay  = abs_coord(ny);
    az  = abs_coord(nz);
    res = AXIS_Z;
    if (ax > ay) begin
      if (ax > az) res = AXIS_X;
    end else if (ay > az) begin
      res = AXIS_Y;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/pa3_shoelace.sv =====
`default_nettype none

module pa3_shoelace #(
  parameter int unsigned MAX_VERTICES = 256
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  pa3_pkg::sl_cmd_e             cmd_i,
  input  pa3_pkg::vtx_t                vert_i,
  input  pa3_pkg::coord_t              normal_x_i,
  input  pa3_pkg::coord_t              normal_y_i,
  input  pa3_pkg::coord_t              normal_z_i,
  output logic [pa3_pkg::SUM_W-1:0]    sum_o,
  output logic                         has_two_o
);

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW    = pa3_pkg::COORD_W;

  pa3_pkg::vtx_t first_q, second_q, prev_q, pprev_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [pa3_pkg::SUM_W-1:0]    sum_q, sum_d;

  pa3_pkg::vtx_t   before_v, mid_v, next_v;
  pa3_pkg::axis_e  axis;
  pa3_pkg::coord_t a, b0, b2;
  logic signed [CW:0]   diff;
  logic signed [2*CW:0] prod;

  // operand choice: running term, or the two closing terms of the ring
  always_comb begin
    unique case (cmd_i)
      pa3_pkg::SL_WRAP_A: begin
        before_v = pprev_q;
        mid_v    = prev_q;
        next_v   = first_q;
      end
      pa3_pkg::SL_WRAP_B: begin
        before_v = prev_q;
        mid_v    = first_q;
        next_v   = second_q;
      end
      default: begin
        before_v = pprev_q;
        mid_v    = prev_q;
        next_v   = vert_i;
      end
    endcase
  end

  // projection onto the plane of the two kept axes
  always_comb begin
    axis = pa3_pkg::drop_axis(normal_x_i, normal_y_i, normal_z_i);
    unique case (axis)
      pa3_pkg::AXIS_X: begin
        a  = mid_v.y;
        b0 = before_v.z;
        b2 = next_v.z;
      end
      pa3_pkg::AXIS_Y: begin
        a  = mid_v.z;
        b0 = before_v.x;
        b2 = next_v.x;
      end
      default: begin
        a  = mid_v.x;
        b0 = before_v.y;
        b2 = next_v.y;
      end
    endcase
  end

  // one multiply-accumulate a * (b_next - b_before), wrapping sum
  always_comb begin
    diff  = {b2[CW-1], b2} - {b0[CW-1], b0};
    prod  = a * diff;
    sum_d = sum_q + pa3_pkg::SUM_W'(prod);
  end

  // vertex count and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      unique case (cmd_i)
        pa3_pkg::SL_VERTEX: begin
          if (has_two_o) sum_q <= sum_d;
          if (cnt_q != CNT_W'(MAX_VERTICES)) cnt_q <= cnt_q + 1'b1;
        end
        pa3_pkg::SL_WRAP_A, pa3_pkg::SL_WRAP_B: begin
          sum_q <= sum_d;
        end
        pa3_pkg::SL_CLEAR: begin
          cnt_q <= '0;
          sum_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // kept vertices: first two and last two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      prev_q   <= '0;
      pprev_q  <= '0;
    end else if (cmd_i == pa3_pkg::SL_VERTEX) begin
      if (cnt_q == '0) begin
        first_q <= vert_i;
      end else if (cnt_q == CNT_W'(1)) begin
        second_q <= vert_i;
        pprev_q  <= prev_q;
      end else begin
        pprev_q  <= prev_q;
      end
      prev_q <= vert_i;
    end
  end

  assign sum_o     = sum_q;
  assign has_two_o = (cnt_q != '0) && (cnt_q != CNT_W'(1));

endmodule

`default_nettype wire

// ===== design/pa3_isqrt.sv =====
`default_nettype none

module pa3_isqrt (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [31:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  // root of rad_i * 2^32, two radicand bits per step
  localparam int unsigned RAD_W  = 32;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned STEPS  = ROOT_W;
  localparam int unsigned CNT_W  = $clog2(STEPS);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W+1:0]  rem_sh, trial;
  logic              fits;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    fits   = (rem_sh >= trial);
    rem_d  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    root_d = {root_q[ROOT_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== design/pa3_scale.sv =====
`default_nettype none

module pa3_scale (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [pa3_pkg::SUM_W-1:0]     sum_i,
  input  pa3_pkg::coord_t               normal_x_i,
  input  pa3_pkg::coord_t               normal_y_i,
  input  pa3_pkg::coord_t               normal_z_i,
  input  pa3_pkg::coord_t               na_i,
  output logic                          done_o,
  output logic [pa3_pkg::AREA_W-1:0]    area_o
);

  localparam int unsigned CW        = pa3_pkg::COORD_W;
  localparam int unsigned SUM_W     = pa3_pkg::SUM_W;
  localparam int unsigned AREA_W    = pa3_pkg::AREA_W;
  localparam int unsigned MUL_A_W   = SUM_W / 2;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned PROD_W    = SUM_W + MUL_B_W;
  localparam int unsigned DEN_SHIFT = 9;
  localparam int unsigned DEN_W     = CW + DEN_SHIFT;
  localparam int unsigned Q_W       = AREA_W + 1;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [Q_W-1:0] POS_MAX = Q_W'(1) << (AREA_W - 1);

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_SQUARE,
    SC_ROOT,
    SC_MULT,
    SC_DIV
  } sc_state_e;

  sc_state_e            state_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SUM_W-1:0]     mag_q;
  logic                 neg_q;
  logic [DEN_W-1:0]     den_q;
  logic [31:0]          n2_q;
  logic [MUL_B_W-1:0]   len_q;
  logic [PROD_W-1:0]    prod_q;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [Q_W-1:0]       quo_q;
  logic                 done_q, sqrt_go_q;

  logic [CW-1:0]        sq_sel;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;
  logic [DEN_W:0]       rem_sh;
  logic                 q_bit;
  logic                 sqrt_done;
  logic [31:0]          sqrt_root;
  logic [Q_W-1:0]       q_sat;

  // shared multiplier: squares of the normal, then |S| * L in two halves
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    sq_sel = pa3_pkg::abs_coord(normal_x_i);
      2'd1:    sq_sel = pa3_pkg::abs_coord(normal_y_i);
      default: sq_sel = pa3_pkg::abs_coord(normal_z_i);
    endcase
    if (state_q == SC_SQUARE) begin
      mul_a = MUL_A_W'(sq_sel);
      mul_b = MUL_B_W'(sq_sel);
    end else begin
      mul_a = cnt_q[0] ? mag_q[SUM_W-1 -: MUL_A_W] : mag_q[MUL_A_W-1:0];
      mul_b = len_q;
    end
    mul_p = mul_a * mul_b;
  end

  // restoring division step, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_q, prod_q[PROD_W-1]};
    q_bit  = (rem_sh >= {1'b0, den_q});
    rem_d  = q_bit ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
  end

  pa3_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_go_q),
    .rad_i  (n2_q),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SC_IDLE;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      sqrt_go_q <= 1'b0;
      mag_q     <= '0;
      neg_q     <= 1'b0;
      den_q     <= '0;
      n2_q      <= '0;
      len_q     <= '0;
      prod_q    <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
    end else begin
      done_q    <= 1'b0;
      sqrt_go_q <= 1'b0;
      unique case (state_q)
        SC_IDLE: begin
          if (start_i) begin
            mag_q   <= sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
            neg_q   <= sum_i[SUM_W-1] ^ na_i[CW-1];
            den_q   <= {pa3_pkg::abs_coord(na_i), DEN_SHIFT'(0)};
            n2_q    <= '0;
            cnt_q   <= '0;
            state_q <= SC_SQUARE;
          end
        end
        SC_SQUARE: begin
          n2_q <= n2_q + mul_p[31:0];
          if (cnt_q == CNT_W'(2)) begin
            cnt_q     <= '0;
            sqrt_go_q <= 1'b1;
            state_q   <= SC_ROOT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        SC_ROOT: begin
          if (sqrt_done) begin
            len_q   <= sqrt_root;
            cnt_q   <= '0;
            state_q <= SC_MULT;
          end
        end
        SC_MULT: begin
          if (cnt_q == '0) begin
            prod_q <= PROD_W'(mul_p);
            cnt_q  <= CNT_W'(1);
          end else begin
            prod_q  <= prod_q + {mul_p, MUL_A_W'(0)};
            cnt_q   <= '0;
            rem_q   <= '0;
            quo_q   <= '0;
            state_q <= SC_DIV;
          end
        end
        SC_DIV: begin
          rem_q  <= rem_d;
          prod_q <= {prod_q[PROD_W-2:0], 1'b0};
          quo_q  <= {quo_q[Q_W-2:0], q_bit};
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            cnt_q   <= '0;
            done_q  <= 1'b1;
            state_q <= SC_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= SC_IDLE;
      endcase
    end
  end

  // sign and saturation, quotient truncated toward zero
  always_comb begin
    if (neg_q) begin
      q_sat  = (quo_q > POS_MAX) ? POS_MAX : quo_q;
      area_o = AREA_W'(~q_sat + 1'b1);
    end else begin
      q_sat  = (quo_q > POS_MAX - 1'b1) ? (POS_MAX - 1'b1) : quo_q;
      area_o = AREA_W'(q_sat);
    end
  end

  assign done_o = done_q;

`ifndef SYNTHESIS
  // a finished division hands the unit back idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> state_q == SC_IDLE)
    else $error("scale unit not idle after finishing");

  // a new job arrives only while the unit is free
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> state_q == SC_IDLE)
    else $error("scale unit started while busy");

  // the root only comes back while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni) sqrt_done |-> state_q == SC_ROOT)
    else $error("square root finished outside the root state");
`endif

endmodule

`default_nettype wire

// ===== design/polygon_area_3d_unit.sv =====
`default_nettype none

// Area of a planar polygon in 3D. The polygon normal is to be written through
// the configuration port (normal_x, normal_y, normal_z at indexes 0, 1, 2)
// only while the unit is idle; the unit does not enforce this. Vertices then
// arrive one beat each with tlast on the final vertex, and that vertex yields
// one result beat: the area in signed Q8 (truncated toward zero, saturated)
// and a status (0 ok, 1 fewer than three vertices, 2 zero normal). A beat is
// taken in the idle state; the shared multiply-accumulate adds its shoelace
// term in the vertex state. A scaled result needs two closing terms, three
// squaring passes through the scaling multiplier, a 32-step square root, two
// partial products and a 76-step restoring divider, one bit each cycle. The
// unit takes no vertex during that time, but a finished result waits in its
// own output register, so the next polygon may start before it is taken.
module polygon_area_3d_unit #(
  parameter int unsigned MAX_VERTICES = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration writes
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_wdata_i,
  // vertex beats
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // vert_x, vert_y, vert_z
  input  wire         s_axis_tlast,   // last_vertex
  // result beats
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata,   // area_q8, zero fill
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int unsigned AREA_W      = pa3_pkg::AREA_W;
  localparam int unsigned OUT_TDATA_W = ((AREA_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VERT,
    ST_WRAP_A,
    ST_WRAP_B,
    ST_FIN,
    ST_SCALE,
    ST_OUT
  } state_e;

  state_e                        state_q;
  pa3_pkg::coord_t               nx_q, ny_q, nz_q;
  pa3_pkg::vtx_t                 vin_q;
  logic                          last_q, degen_q;
  logic [AREA_W-1:0]             res_area_q, m_area_q;
  logic [pa3_pkg::STATUS_W-1:0]  res_status_q, m_status_q;
  logic                          m_valid_q;

  pa3_pkg::sl_cmd_e              sl_cmd;
  logic [pa3_pkg::SUM_W-1:0]     sl_sum;
  logic                          sl_has_two;
  pa3_pkg::axis_e                axis;
  pa3_pkg::coord_t               na;
  logic                          scale_start, scale_done;
  logic [AREA_W-1:0]             scale_area;

  // normal component of the dropped axis
  always_comb begin
    axis = pa3_pkg::drop_axis(nx_q, ny_q, nz_q);
    unique case (axis)
      pa3_pkg::AXIS_X: na = nx_q;
      pa3_pkg::AXIS_Y: na = ny_q;
      default:         na = nz_q;
    endcase
  end

  // accumulator commands follow the sequencer state
  always_comb begin
    unique case (state_q)
      ST_VERT:   sl_cmd = pa3_pkg::SL_VERTEX;
      ST_WRAP_A: sl_cmd = pa3_pkg::SL_WRAP_A;
      ST_WRAP_B: sl_cmd = pa3_pkg::SL_WRAP_B;
      ST_FIN:    sl_cmd = pa3_pkg::SL_CLEAR;
      default:   sl_cmd = pa3_pkg::SL_NOP;
    endcase
  end

  // scaling reads the closed sum on the same edge as the clear
  assign scale_start = (state_q == ST_FIN) && !degen_q && (na != '0);

  pa3_shoelace #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_shoelace (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (sl_cmd),
    .vert_i    (vin_q),
    .normal_x_i(nx_q),
    .normal_y_i(ny_q),
    .normal_z_i(nz_q),
    .sum_o     (sl_sum),
    .has_two_o (sl_has_two)
  );

  pa3_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scale_start),
    .sum_i     (sl_sum),
    .normal_x_i(nx_q),
    .normal_y_i(ny_q),
    .normal_z_i(nz_q),
    .na_i      (na),
    .done_o    (scale_done),
    .area_o    (scale_area)
  );

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      nx_q         <= '0;
      ny_q         <= '0;
      nz_q         <= pa3_pkg::coord_t'(1);
      vin_q        <= '0;
      last_q       <= 1'b0;
      degen_q      <= 1'b0;
      res_area_q   <= '0;
      res_status_q <= pa3_pkg::STATUS_OK;
      m_valid_q    <= 1'b0;
      m_area_q     <= '0;
      m_status_q   <= pa3_pkg::STATUS_OK;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pa3_pkg::REG_NORMAL_X: nx_q <= cfg_wdata_i;
          pa3_pkg::REG_NORMAL_Y: ny_q <= cfg_wdata_i;
          pa3_pkg::REG_NORMAL_Z: nz_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      // a taken beat empties the output register unless a new one loads
      if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) m_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            vin_q   <= s_axis_tdata;
            last_q  <= s_axis_tlast;
            state_q <= ST_VERT;
          end
        end
        ST_VERT: begin
          if (last_q) begin
            degen_q <= !sl_has_two;
            state_q <= sl_has_two ? ST_WRAP_A : ST_FIN;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_WRAP_A: state_q <= ST_WRAP_B;
        ST_WRAP_B: state_q <= ST_FIN;
        ST_FIN: begin
          if (degen_q) begin
            res_area_q   <= '0;
            res_status_q <= pa3_pkg::STATUS_DEGEN;
            state_q      <= ST_OUT;
          end else if (na == '0) begin
            res_area_q   <= '0;
            res_status_q <= pa3_pkg::STATUS_ZERO_NORMAL;
            state_q      <= ST_OUT;
          end else begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (scale_done) begin
            res_area_q   <= scale_area;
            res_status_q <= pa3_pkg::STATUS_OK;
            state_q      <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q  <= 1'b1;
            m_area_q   <= res_area_q;
            m_status_q <= res_status_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_area_q);
  assign m_axis_tuser  = m_status_q;

`ifndef SYNTHESIS
  // the scaling unit only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   scale_done |-> state_q == ST_SCALE)
    else $error("scale result with no polygon waiting");

  // closing a polygon leaves the accumulator empty for the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_FIN) |=> !sl_has_two)
    else $error("polygon state not cleared after a result");

  // a result beat appears only from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result beat raised outside the output state");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_polygon_area_3d_unit.sv =====
`timescale 1ns / 100ps

module tb_polygon_area_3d_unit;

  typedef longint unsigned u64_t;

  localparam int unsigned VERT_LIMIT   = 256;
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam pa3_pkg::coord_t C_MIN = 16'sh8000;
  localparam pa3_pkg::coord_t C_MAX = 16'sh7fff;

  localparam u64_t AREA_NEG_MAG = u64_t'(1) << (pa3_pkg::AREA_W - 1);
  localparam u64_t AREA_POS_MAX = AREA_NEG_MAG - 1;

  // how the vertices of one polygon are drawn
  typedef enum int {
    POLY_RANDOM,
    POLY_EXTREME,
    POLY_SMALL,
    POLY_SQUARE
  } poly_style_e;

  typedef struct packed {
    logic [pa3_pkg::AREA_W-1:0]   area;
    logic [pa3_pkg::STATUS_W-1:0] status;
  } area_result_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [pa3_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0]                   cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [47:0]                   s_axis_tdata;   // vert_x, vert_y, vert_z
  logic                          s_axis_tlast;   // last_vertex
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [55:0]                   m_axis_tdata;   // area_q8, zero fill
  logic [1:0]                    m_axis_tuser;   // status

  polygon_area_3d_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // polygon area predictor and queue of areas still owed by the unit
  class area_scoreboard;
    pa3_pkg::coord_t           nrm_x;
    pa3_pkg::coord_t           nrm_y;
    pa3_pkg::coord_t           nrm_z;
    pa3_pkg::vtx_t             first_v;
    pa3_pkg::vtx_t             second_v;
    pa3_pkg::vtx_t             prev_v;
    pa3_pkg::vtx_t             prev_prev_v;
    logic [pa3_pkg::SUM_W-1:0] sum;
    int unsigned               count;
    area_result_t              area_q[$];
    int unsigned               fails;

    function new();
      nrm_x = 0;
      nrm_y = 0;
      nrm_z = 1;
      fails = 0;
      clear();
    endfunction

    function void clear();
      first_v     = '0;
      second_v    = '0;
      prev_v      = '0;
      prev_prev_v = '0;
      sum         = '0;
      count       = 0;
    endfunction

    function void set_normal(pa3_pkg::coord_t nx, pa3_pkg::coord_t ny, pa3_pkg::coord_t nz);
      nrm_x = nx;
      nrm_y = ny;
      nrm_z = nz;
    endfunction

    function int unsigned pending();
      return area_q.size();
    endfunction

    // axis of the largest normal magnitude; ties fall to z, or y on an x-y tie
    function pa3_pkg::axis_e pick_axis();
      int ax;
      int ay;
      int az;
      ax = (nrm_x < 0) ? -int'(nrm_x) : int'(nrm_x);
      ay = (nrm_y < 0) ? -int'(nrm_y) : int'(nrm_y);
      az = (nrm_z < 0) ? -int'(nrm_z) : int'(nrm_z);
      if (ax > ay && ax > az) return pa3_pkg::AXIS_X;
      if (ax <= ay && ay > az) return pa3_pkg::AXIS_Y;
      return pa3_pkg::AXIS_Z;
    endfunction

    function void project(pa3_pkg::vtx_t v, pa3_pkg::axis_e ax,
                          output longint pa, output longint pb);
      case (ax)
        pa3_pkg::AXIS_X: begin
          pa = v.y;
          pb = v.z;
        end
        pa3_pkg::AXIS_Y: begin
          pa = v.z;
          pb = v.x;
        end
        default: begin
          pa = v.x;
          pb = v.y;
        end
      endcase
    endfunction

    // one shoelace term, wrapping at the accumulator width
    function void add_term(pa3_pkg::vtx_t lo_v, pa3_pkg::vtx_t mid_v, pa3_pkg::vtx_t hi_v);
      pa3_pkg::axis_e ax;
      longint         a;
      longint         b0;
      longint         b2;
      longint         unused;
      ax = pick_axis();
      project(mid_v, ax, a, unused);
      project(lo_v, ax, unused, b0);
      project(hi_v, ax, unused, b2);
      sum = sum + pa3_pkg::SUM_W'(a * (b2 - b0));
    endfunction

    function u64_t root64(u64_t m);
      u64_t r;
      u64_t cand;
      int   i;
      r = 0;
      for (i = 31; i >= 0; i--) begin
        cand = r | (u64_t'(1) << i);
        if (cand * cand <= m) r = cand;
      end
      return r;
    endfunction

    // scale the sum by |N| / (2 * N_axis) into Q8, truncate toward zero, saturate
    function area_result_t scaled_area();
      area_result_t   res;
      pa3_pkg::axis_e ax;
      int             na;
      longint         s;
      longint         sq;
      u64_t           len;
      u64_t           mag;
      u64_t           q;
      logic [127:0]   prod;
      logic [127:0]   den;
      bit             neg;
      ax = pick_axis();
      na = (ax == pa3_pkg::AXIS_X) ? int'(nrm_x) :
           (ax == pa3_pkg::AXIS_Y) ? int'(nrm_y) : int'(nrm_z);
      if (na == 0) begin
        res.area   = '0;
        res.status = pa3_pkg::STATUS_ZERO_NORMAL;
        return res;
      end
      s    = longint'($signed(sum));
      sq   = longint'(nrm_x) * nrm_x + longint'(nrm_y) * nrm_y + longint'(nrm_z) * nrm_z;
      len  = root64(u64_t'(sq) << 32);
      mag  = (s < 0) ? u64_t'(-s) : u64_t'(s);
      prod = 128'(mag) * 128'(len);
      den  = 128'(512 * ((na < 0) ? -na : na));
      q    = 64'(prod / den);
      neg  = (s < 0) != (na < 0);
      if (neg) begin
        if (q > AREA_NEG_MAG) q = AREA_NEG_MAG;
        res.area = pa3_pkg::AREA_W'(u64_t'(0) - q);
      end else begin
        if (q > AREA_POS_MAX) q = AREA_POS_MAX;
        res.area = pa3_pkg::AREA_W'(q);
      end
      res.status = pa3_pkg::STATUS_OK;
      return res;
    endfunction

    // accepted vertex beat
    function void note_vertex(pa3_pkg::vtx_t v, bit last);
      area_result_t res;
      if (count == 0) begin
        first_v = v;
      end else if (count == 1) begin
        second_v    = v;
        prev_prev_v = prev_v;
      end else begin
        add_term(prev_prev_v, prev_v, v);
        prev_prev_v = prev_v;
      end
      prev_v = v;
      if (count < VERT_LIMIT) count++;
      if (!last) return;
      if (count < 3) begin
        res.area   = '0;
        res.status = pa3_pkg::STATUS_DEGEN;
      end else begin
        add_term(prev_prev_v, prev_v, first_v);
        add_term(prev_v, first_v, second_v);
        res = scaled_area();
      end
      area_q.push_back(res);
      clear();
    endfunction

    // accepted result beat
    function void check_result(logic [pa3_pkg::AREA_W-1:0] area,
                               logic [pa3_pkg::STATUS_W-1:0] status);
      area_result_t want;
      if (area_q.size() == 0) begin
        fails++;
        if (fails <= REPORT_LIMIT)
          $display("unexpected result beat: area %0d status %0d", $signed(area), status);
        return;
      end
      want = area_q.pop_front();
      if (want.area !== area || want.status !== status) begin
        fails++;
        if (fails <= REPORT_LIMIT)
          $display("area mismatch: expected %0d status %0d, got %0d status %0d",
                   $signed(want.area), want.status, $signed(area), status);
      end
    endfunction
  endclass

  area_scoreboard sb;
  bit             burst;        // no idling on either side while set
  int unsigned    quiet_cycles;

  int normal_table [8][3] = '{
    '{32767, 0, 0}, '{-32768, 32767, 32767}, '{0, -32768, 0}, '{0, 0, -32768},
    '{5, 5, 2}, '{3, -3, 3}, '{-7, 2, -7}, '{0, 0, 0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on cycles without any accepted beat
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic pa3_pkg::vtx_t mk_vtx(int x, int y, int z);
    pa3_pkg::vtx_t v;
    v.x = pa3_pkg::coord_t'(x);
    v.y = pa3_pkg::coord_t'(y);
    v.z = pa3_pkg::coord_t'(z);
    return v;
  endfunction

  function automatic pa3_pkg::coord_t rand_coord(poly_style_e style);
    case (style)
      POLY_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return C_MIN;
          1: return C_MAX;
          2: return pa3_pkg::coord_t'(0);
          default: return pa3_pkg::coord_t'(-1);
        endcase
      end
      POLY_SMALL: return pa3_pkg::coord_t'(int'($urandom_range(0, 200)) - 100);
      default: begin
        case ($urandom_range(0, 7))
          0: return C_MIN;
          1: return C_MAX;
          2: return pa3_pkg::coord_t'(int'($urandom_range(0, 200)) - 100);
          default: return pa3_pkg::coord_t'($urandom());
        endcase
      end
    endcase
  endfunction

  // corners of the extreme square, counter-clockwise in x-y
  function automatic pa3_pkg::vtx_t square_vtx(int unsigned i);
    pa3_pkg::vtx_t v;
    v.z = pa3_pkg::coord_t'($urandom());
    case (i % 4)
      0: begin v.x = C_MAX; v.y = C_MIN; end
      1: begin v.x = C_MAX; v.y = C_MAX; end
      2: begin v.x = C_MIN; v.y = C_MAX; end
      default: begin v.x = C_MIN; v.y = C_MIN; end
    endcase
    return v;
  endfunction

  function automatic pa3_pkg::coord_t rand_component();
    case ($urandom_range(0, 7))
      0: return pa3_pkg::coord_t'(0);
      1: return C_MIN;
      2: return C_MAX;
      3: return pa3_pkg::coord_t'(int'($urandom_range(0, 20)) - 10);
      default: return pa3_pkg::coord_t'($urandom());
    endcase
  endfunction

  task automatic write_reg(logic [pa3_pkg::CFG_IDX_W-1:0] idx, pa3_pkg::coord_t val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
  endtask

  task automatic program_normal(pa3_pkg::coord_t nx, pa3_pkg::coord_t ny,
                                pa3_pkg::coord_t nz);
    write_reg(pa3_pkg::REG_NORMAL_X, nx);
    write_reg(pa3_pkg::REG_NORMAL_Y, ny);
    write_reg(pa3_pkg::REG_NORMAL_Z, nz);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_normal(nx, ny, nz);
  endtask

  // sender holds off until every owed area is back, then lets the divider settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_vertex(pa3_pkg::vtx_t v, bit last);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = v;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_vertex(v, last);
  endtask

  task automatic send_polygon(int unsigned n, poly_style_e style);
    pa3_pkg::vtx_t v;
    int unsigned   i;
    for (i = 0; i < n; i++) begin
      if (style == POLY_SQUARE) begin
        v = square_vtx(i);
      end else begin
        v.x = rand_coord(style);
        v.y = rand_coord(style);
        v.z = rand_coord(style);
      end
      push_vertex(v, i == n - 1);
    end
  endtask

  // result side: random stall before each beat, then take it
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata[pa3_pkg::AREA_W-1:0], m_axis_tuser);
    end
  end

  initial begin
    int              p;
    int unsigned     sent;
    int unsigned     n;
    int unsigned     pick;
    pa3_pkg::coord_t nx;
    pa3_pkg::coord_t ny;
    pa3_pkg::coord_t nz;
    poly_style_e     style;

    sb            = new();
    burst         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset normal, short polygons, extreme coordinates
    push_vertex(mk_vtx(-32768, -32768, -32768), 1'b1);
    push_vertex(mk_vtx(32767, 32767, 32767), 1'b0);
    push_vertex(mk_vtx(0, 0, 0), 1'b1);
    push_vertex(mk_vtx(-32768, -32768, 0), 1'b0);
    push_vertex(mk_vtx(32767, -32768, -1), 1'b0);
    push_vertex(mk_vtx(0, 32767, 32767), 1'b1);
    push_vertex(mk_vtx(32767, 32767, -32768), 1'b0);
    push_vertex(mk_vtx(-32768, 32767, 1), 1'b0);
    push_vertex(mk_vtx(-32768, -32768, 2), 1'b0);
    push_vertex(mk_vtx(32767, -32768, 3), 1'b1);
    drain();

    // zero normal, and a short polygon that reports degenerate first
    program_normal(pa3_pkg::coord_t'(0), pa3_pkg::coord_t'(0), pa3_pkg::coord_t'(0));
    push_vertex(mk_vtx(100, -200, 300), 1'b0);
    push_vertex(mk_vtx(-32768, 32767, 5), 1'b0);
    push_vertex(mk_vtx(32767, 7, -9), 1'b1);
    push_vertex(mk_vtx(1, 2, 3), 1'b0);
    push_vertex(mk_vtx(4, 5, 6), 1'b1);
    drain();

    // all components tied at the most negative value
    program_normal(C_MIN, C_MIN, C_MIN);
    push_vertex(mk_vtx(-32768, 32767, -32768), 1'b0);
    push_vertex(mk_vtx(32767, -32768, 32767), 1'b0);
    push_vertex(mk_vtx(-1, 0, 32767), 1'b1);
    drain();

    // long polygons: vertex count saturation and a large area
    program_normal(pa3_pkg::coord_t'(1), pa3_pkg::coord_t'(1), pa3_pkg::coord_t'(1));
    burst = 1'b1;
    send_polygon(520, POLY_SQUARE);
    burst = 1'b0;
    send_polygon(280, POLY_RANDOM);
    drain();

    // random phases, each with its own normal
    for (p = 0; p < PHASES; p++) begin
      if (p < 8) begin
        nx = pa3_pkg::coord_t'(normal_table[p][0]);
        ny = pa3_pkg::coord_t'(normal_table[p][1]);
        nz = pa3_pkg::coord_t'(normal_table[p][2]);
      end else begin
        nx = rand_component();
        ny = rand_component();
        nz = rand_component();
        // force magnitude ties now and then
        case ($urandom_range(0, 3))
          0: ny = $urandom_range(0, 1) ? nx : -nx;
          1: nz = $urandom_range(0, 1) ? ny : -ny;
          2: nz = $urandom_range(0, 1) ? nx : -nx;
          default: ;
        endcase
      end
      program_normal(nx, ny, nz);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 15))
          0: n = 1;
          1: n = 2;
          2: n = $urandom_range(17, 48);
          default: n = $urandom_range(3, 12);
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0) style = POLY_EXTREME;
        else if (pick == 1) style = POLY_SMALL;
        else if (pick == 2) style = POLY_SQUARE;
        else style = POLY_RANDOM;
        burst = ($urandom_range(0, 7) == 0);
        send_polygon(n, style);
        sent += n;
      end
      burst = 1'b0;
      drain();
    end

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
